// ===== hw/rtl/xtce_pkg.sv =====
// ----------------------------------------------------------------------------
// xtce_pkg: shared types and constants of the XML tag content extractor
// Tag window geometry, result kinds, phase codes, register indexes, and the
// tag name byte lookup.
// ----------------------------------------------------------------------------
package xtce_pkg;

  localparam int MAX_TAG_LEN = 16;
  localparam int WIN_DEPTH   = MAX_TAG_LEN + 3;
  localparam int LEN_W       = 5;
  localparam int IDX_W       = $clog2(WIN_DEPTH);
  localparam int CHARS_W     = 64;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  // phase codes
  localparam logic [1:0] PH_SEEK    = 2'd0;
  localparam logic [1:0] PH_CONTENT = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CONTENT   = 2'd0;
  localparam logic [1:0] KIND_FOUND     = 2'd1;
  localparam logic [1:0] KIND_NOT_FOUND = 2'd2;

  // register indexes
  localparam logic [1:0] REG_TAG_CHARS_LOW  = 2'd0;
  localparam logic [1:0] REG_TAG_CHARS_HIGH = 2'd1;
  localparam logic [1:0] REG_TAG_LENGTH     = 2'd2;

  // markup characters
  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef struct packed {
    logic [CHARS_W-1:0] chars_low;
    logic [CHARS_W-1:0] chars_high;
    logic [LEN_W-1:0]   len;
  } tag_cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } result_t;

  // up to two result words per input word, first in order first
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic logic [7:0] name_byte(tag_cfg_t c, logic [3:0] j);
    logic [2*CHARS_W-1:0] chars;
    chars = {c.chars_high, c.chars_low};
    return chars[{j, 3'b000} +: 8];
  endfunction

endpackage

// ===== hw/rtl/xtce_window.sv =====
// ----------------------------------------------------------------------------
// xtce_window: tag window and phase tracking
// Shifts document bytes into a tag-length+3 window, matches opening and
// closing tags in parallel, and produces the result words of each byte.
// ----------------------------------------------------------------------------
module xtce_window (
  input  logic              clk,
  input  logic              rst,
  input  xtce_pkg::tag_cfg_t cfg,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output xtce_pkg::push_t   push
);
  import xtce_pkg::*;

  logic [7:0]           win_byte [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] win_valid;
  logic [1:0]           phase;
  logic [1:0]           phase_next;

  logic [LEN_W-1:0]     eff_len;
  logic [IDX_W-1:0]     win_len;
  logic [IDX_W-1:0]     tap;
  logic [IDX_W-1:0]     pos_lt_open;
  logic [IDX_W-1:0]     pos_lt_close;

  logic [7:0]           shift_byte [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] shift_valid;
  logic [WIN_DEPTH-1:0] lt_vec;
  logic [WIN_DEPTH-1:0] slash_vec;
  logic [MAX_TAG_LEN:1] name_ok;
  logic [LEN_W-1:0]     name_idx [1:MAX_TAG_LEN];

  logic gt_hit, open_hit, close_hit;
  logic emit_byte, emit_status, clear_win, shift_en;
  logic [1:0] status_kind;
  logic [1:0] phase_after;
  result_t    byte_res, status_res;

  assign eff_len      = (cfg.len > LEN_W'(MAX_TAG_LEN)) ? LEN_W'(MAX_TAG_LEN) : cfg.len;
  assign win_len      = IDX_W'(eff_len) + IDX_W'(3);
  assign tap          = IDX_W'(eff_len) + IDX_W'(2);
  assign pos_lt_open  = IDX_W'(eff_len) + IDX_W'(1);
  assign pos_lt_close = IDX_W'(eff_len) + IDX_W'(2);

  // shift the new byte in and drop taps past the current window length
  always_comb begin
    shift_byte[0]  = in_byte;
    shift_valid[0] = 1'b1;
    for (int k = 1; k < WIN_DEPTH; k++) begin
      shift_byte[k]  = win_byte[k-1];
      shift_valid[k] = (IDX_W'(k) < win_len) && win_valid[k-1];
    end
    for (int k = 0; k < WIN_DEPTH; k++) begin
      lt_vec[k]    = shift_valid[k] && (shift_byte[k] == CHAR_LT);
      slash_vec[k] = shift_valid[k] && (shift_byte[k] == CHAR_SLASH);
    end
  end

  // tap p holds name byte len-p
  always_comb begin
    for (int p = 1; p <= MAX_TAG_LEN; p++) begin
      name_idx[p] = eff_len - LEN_W'(p);
      name_ok[p]  = (LEN_W'(p) > eff_len) ||
                    (shift_valid[p] && (shift_byte[p] == name_byte(cfg, name_idx[p][3:0])));
    end
  end

  assign gt_hit    = shift_valid[0] && (shift_byte[0] == CHAR_GT) && (&name_ok);
  assign open_hit  = gt_hit && lt_vec[pos_lt_open];
  assign close_hit = gt_hit && slash_vec[pos_lt_open] && lt_vec[pos_lt_close];

  always_comb begin
    emit_byte   = (phase == PH_CONTENT) && win_valid[tap];
    emit_status = 1'b0;
    status_kind = KIND_NOT_FOUND;
    clear_win   = 1'b0;
    shift_en    = (phase != PH_DONE);
    phase_after = phase;

    case (phase)
      PH_SEEK: begin
        if (close_hit) begin
          emit_status = 1'b1;
          status_kind = KIND_NOT_FOUND;
          phase_after = PH_DONE;
        end else if (open_hit) begin
          clear_win   = 1'b1;
          phase_after = PH_CONTENT;
        end
      end
      PH_CONTENT: begin
        if (close_hit) begin
          emit_status = 1'b1;
          status_kind = KIND_FOUND;
          phase_after = PH_DONE;
        end
      end
      default: begin
        phase_after = phase;
      end
    endcase

    if (in_last && (phase_after != PH_DONE)) begin
      emit_status = 1'b1;
      status_kind = KIND_NOT_FOUND;
    end

    phase_next = phase_after;
    if (in_last) begin
      clear_win  = 1'b1;
      phase_next = PH_SEEK;
    end

    byte_res   = '{data: win_byte[tap], kind: KIND_CONTENT, last: 1'b0};
    status_res = '{data: 8'd0, kind: status_kind, last: 1'b1};

    push = '0;
    if (step) begin
      push.count = {1'b0, emit_byte} + {1'b0, emit_status};
      if (emit_byte) begin
        push.first  = byte_res;
        push.second = status_res;
      end else begin
        push.first  = status_res;
        push.second = status_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= '0;
      phase     <= PH_SEEK;
    end else if (step) begin
      phase <= phase_next;
      if (clear_win) begin
        win_valid <= '0;
      end else if (shift_en) begin
        win_valid <= shift_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && shift_en) begin
      win_byte <= shift_byte;
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (step && in_last) |=> (phase == PH_SEEK))
    else $error("phase did not return to seek after end of document");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (step && (phase == PH_DONE)) |-> (push.count == 2'd0))
    else $error("result produced after the document was settled");

endmodule

// ===== hw/rtl/xtce_fifo.sv =====
// ----------------------------------------------------------------------------
// xtce_fifo: output word queue
// Takes up to two result words per cycle and hands one word per cycle to
// the output channel whenever it pops one.
// ----------------------------------------------------------------------------
module xtce_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  xtce_pkg::push_t               push,
  input  logic                          pop,
  output xtce_pkg::result_t             head,
  output logic                          not_empty,
  output logic [xtce_pkg::FIFO_CNT_W-1:0] count
);
  import xtce_pkg::*;

  result_t               mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] wr_ptr_1;

  assign wr_ptr_1  = wr_ptr + FIFO_PTR_W'(1);
  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

endmodule

// ===== hw/rtl/xml_tag_content_extractor.sv =====
// ----------------------------------------------------------------------------
// xml_tag_content_extractor: stream out the content of one XML element
// Results: each result word is written into the output queue as its byte
//   is accepted, and is offered on the output from the queue's head.
// Throughput: one byte per cycle; the tag window compare is fully parallel.
//   A byte can yield two words (content plus status), so the output queue
//   holds the input back while it cannot take two more words, which happens
//   only while the output side lags.
// Reset: synchronous; clears phase, window valid bits and queue, and sets
//   the tag name to empty bytes with length one.
// ----------------------------------------------------------------------------
module xml_tag_content_extractor (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // document byte words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  out_kind,
  output logic        out_last
);
  import xtce_pkg::*;

  tag_cfg_t              cfg;
  push_t                 push;
  result_t               head;
  logic                  step;
  logic                  pop;
  logic                  not_empty;
  logic [FIFO_CNT_W-1:0] fifo_count;

  // Tag registers, taken directly: write them only while the block is idle,
  // which the block does not enforce. The new name is used from the next byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chars_low  <= '0;
      cfg.chars_high <= '0;
      cfg.len        <= LEN_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TAG_CHARS_LOW:  cfg.chars_low  <= cfg_data;
        REG_TAG_CHARS_HIGH: cfg.chars_high <= cfg_data;
        REG_TAG_LENGTH:     cfg.len        <= cfg_data[LEN_W-1:0];
        default:            cfg.len        <= cfg.len;
      endcase
    end
  end

  // Hold the input whenever the queue cannot absorb the worst case of two
  // words from the next byte.
  assign in_stall = (fifo_count > FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign step     = in_valid && !in_stall;

  // Window, tag match and phase: all of one byte's work is done as it is accepted.
  xtce_window u_window (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (step),
    .in_byte (in_byte),
    .in_last (in_last),
    .push    (push)
  );

  // Output queue doubles as the result register and decouples the sides.
  xtce_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .count     (fifo_count)
  );

  assign out_valid = not_empty;
  assign pop       = out_valid && !out_stall;
  assign out_byte  = head.data;
  assign out_kind  = head.kind;
  assign out_last  = head.last;

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind != KIND_CONTENT)) |-> ((out_byte == 8'd0) && out_last))
    else $error("status word carries data or lacks the end mark");

endmodule

// ===== tb/xml_tag_content_extractor_tb.sv =====
// ----------------------------------------------------------------------------
// xml_tag_content_extractor_tb: self-checking bench for the tag extractor
// Feeds byte documents (well-formed elements, missing closes, closes ahead of
// opens, corrupted tags and plain noise) under a sequence of tag names and
// lengths, predicts every content and status word in a scoreboard, and
// compares each word taken from the output in order, with random gaps and
// stalls on both sides.
// ----------------------------------------------------------------------------
module xml_tag_content_extractor_tb;
  import xtce_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 105;
  localparam int HOLD_CYCLES  = 400;
  // extra settling wait once no words are owed
  localparam int SETTLE       = 4;

  // Scoreboard: tracks the tag window and phase of the extractor and keeps
  // the result words still owed by the block, oldest first.
  class tag_extract_scoreboard;
    logic [63:0] chars_lo;
    logic [63:0] chars_hi;
    logic [4:0]  len_reg;
    logic [7:0]  win_b [WIN_DEPTH];
    bit          win_v [WIN_DEPTH];
    logic [1:0]  phase;
    result_t     owed_q [$];
    int          errors;

    function new();
      chars_lo = '0;
      chars_hi = '0;
      len_reg  = 5'd1;
      phase    = PH_SEEK;
      errors   = 0;
      clear_window();
    endfunction

    function void clear_window();
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win_b[k] = '0;
        win_v[k] = 1'b0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
        REG_TAG_CHARS_LOW:  chars_lo = value;
        REG_TAG_CHARS_HIGH: chars_hi = value;
        REG_TAG_LENGTH:     len_reg  = value[4:0];
        default: ;
      endcase
    endfunction

    // lengths beyond the window saturate
    function int tag_len();
      return (len_reg > MAX_TAG_LEN) ? MAX_TAG_LEN : int'(len_reg);
    endfunction

    function logic [7:0] tag_char(int j);
      logic [127:0] all_chars;
      all_chars = {chars_hi, chars_lo};
      return all_chars[8*(j & 15) +: 8];
    endfunction

    function bit holds(int idx, logic [7:0] b);
      if (idx >= WIN_DEPTH) return 1'b0;
      return win_v[idx] && (win_b[idx] == b);
    endfunction

    // newest bytes read "<name>" or "</name>", newest at index 0
    function bit tag_at_head(bit closing);
      int n;
      n = tag_len();
      if (!holds(0, CHAR_GT)) return 1'b0;
      for (int j = 0; j < n; j++)
        if (!holds(n - j, tag_char(j))) return 1'b0;
      if (closing) return holds(n + 1, CHAR_SLASH) && holds(n + 2, CHAR_LT);
      return holds(n + 1, CHAR_LT);
    endfunction

    function void owe(logic [7:0] d, logic [1:0] k, logic l);
      owed_q.push_back(result_t'{data: d, kind: k, last: l});
    endfunction

    // advance the window by one accepted byte and queue the words it causes
    function void note_input(logic [7:0] b, bit doc_end);
      int w;
      w = tag_len() + 3;
      if (phase == PH_CONTENT && win_v[w-1]) owe(win_b[w-1], KIND_CONTENT, 1'b0);
      if (phase != PH_DONE) begin
        for (int k = WIN_DEPTH - 1; k > 0; k--) begin
          win_b[k] = win_b[k-1];
          win_v[k] = win_v[k-1];
        end
        win_b[0] = b;
        win_v[0] = 1'b1;
        for (int k = w; k < WIN_DEPTH; k++) begin
          win_b[k] = '0;
          win_v[k] = 1'b0;
        end
        if (phase == PH_SEEK) begin
          if (tag_at_head(1'b1)) begin
            owe(8'h00, KIND_NOT_FOUND, 1'b1);
            phase = PH_DONE;
          end else if (tag_at_head(1'b0)) begin
            clear_window();
            phase = PH_CONTENT;
          end
        end else if (tag_at_head(1'b1)) begin
          owe(8'h00, KIND_FOUND, 1'b1);
          phase = PH_DONE;
        end
        if (doc_end && phase != PH_DONE) owe(8'h00, KIND_NOT_FOUND, 1'b1);
      end
      if (doc_end) begin
        clear_window();
        phase = PH_SEEK;
      end
    endfunction

    function void check_result(logic [7:0] d, logic [1:0] k, logic l);
      result_t e;
      if (owed_q.size() == 0) begin
        $error("unexpected result word: out_byte %0h out_kind %0d out_last %0b", d, k, l);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      if (d !== e.data) begin
        $error("out_byte: expected %0h, got %0h", e.data, d);
        errors++;
      end
      if (k !== e.kind) begin
        $error("out_kind: expected %0d, got %0d", e.kind, k);
        errors++;
      end
      if (l !== e.last) begin
        $error("out_last: expected %0b, got %0b", e.last, l);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  out_kind;
  logic        out_last;

  tag_extract_scoreboard sb;

  // tag name as the documents spell it for the current register setting
  logic [7:0] tag_name [16];
  int         tag_eff;
  logic [7:0] doc_q [$];
  bit         quiet_doc;

  // receiver hold-off: the driver bumps hold_req, the receiver counts it out
  int hold_req   = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int stall_left = 0;
  int free_left  = 0;
  int cycles     = 0;

  xml_tag_content_extractor dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_kind  (out_kind),
    .out_last  (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: check every word taken at this edge, then pick the stall for
  // the next cycle. Short stalls dominate, with a few long ones and some
  // quiet stretches; a requested hold-off overrides both.
  always @(posedge clk) begin
    int r;
    if (!rst && out_valid && !out_stall) sb.check_result(out_byte, out_kind, out_last);
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        free_left = $urandom_range(20, 80);
      end else if (r < 22) begin
        stall_left = $urandom_range(10, 40);
      end else begin
        stall_left = $urandom_range(0, 3);
        free_left  = $urandom_range(1, 6);
      end
      out_stall <= 1'b0;
    end
  end

  // gap after a byte: mostly none, some short, a few long
  function automatic int pause_len();
    int r;
    if (quiet_doc) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one byte word, hold it until taken, then note it and maybe idle.
  task automatic send_word(input logic [7:0] b, input logic doc_end);
    int gap;
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= doc_end;
    do @(posedge clk); while (in_stall);
    sb.note_input(b, doc_end);
    gap = pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until the block owes nothing and has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all three registers back to back; lower the enable once at the end.
  task automatic load_tag(input logic [127:0] chars, input logic [63:0] len_word);
    cfg_write <= 1'b1;
    cfg_index <= REG_TAG_CHARS_LOW;
    cfg_data  <= chars[63:0];
    @(posedge clk);
    sb.write_reg(REG_TAG_CHARS_LOW, chars[63:0]);
    cfg_index <= REG_TAG_CHARS_HIGH;
    cfg_data  <= chars[127:64];
    @(posedge clk);
    sb.write_reg(REG_TAG_CHARS_HIGH, chars[127:64]);
    cfg_index <= REG_TAG_LENGTH;
    cfg_data  <= len_word;
    @(posedge clk);
    sb.write_reg(REG_TAG_LENGTH, len_word);
    cfg_write <= 1'b0;
  endtask

  // Filler leans on markup characters and name bytes so that partial and
  // false tags show up often inside content and noise.
  function automatic logic [7:0] filler();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'h61 + 8'($urandom_range(0, 25));
    if (r < 68) return CHAR_LT;
    if (r < 74) return CHAR_SLASH;
    if (r < 80) return CHAR_GT;
    if (r < 90) return tag_name[$urandom_range(0, 15)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void put_fill(int n);
    repeat (n) doc_q.push_back(filler());
  endfunction

  function automatic void put_tag(bit closing);
    doc_q.push_back(CHAR_LT);
    if (closing) doc_q.push_back(CHAR_SLASH);
    for (int j = 0; j < tag_eff; j++) doc_q.push_back(tag_name[j]);
    doc_q.push_back(CHAR_GT);
  endfunction

  // Build one document in doc_q; return how many of its bytes the block
  // still acts on (bytes after a completed status are ignored).
  function automatic int build_doc();
    int r;
    int useful;
    int at;
    doc_q.delete();
    r = $urandom_range(0, 99);
    put_fill($urandom_range(0, 4));
    if (r < 62) begin
      // well-formed element with random content
      put_tag(1'b0);
      put_fill($urandom_range(0, 16));
      put_tag(1'b1);
      useful = doc_q.size();
      put_fill($urandom_range(0, 3));
    end else if (r < 72) begin
      // opened, never closed
      put_tag(1'b0);
      put_fill($urandom_range(0, 16));
      useful = doc_q.size();
    end else if (r < 80) begin
      // closing tag ahead of any opening tag
      put_tag(1'b1);
      useful = doc_q.size();
      put_fill($urandom_range(0, 4));
      if ($urandom_range(0, 1)) put_tag(1'b0);
    end else if (r < 90) begin
      // closing tag with one corrupted byte
      put_tag(1'b0);
      put_fill($urandom_range(0, 8));
      at = doc_q.size();
      put_tag(1'b1);
      doc_q[$urandom_range(at, doc_q.size() - 1)] = filler();
      put_fill($urandom_range(0, 4));
      useful = doc_q.size();
    end else begin
      put_fill($urandom_range(1, 16));
      useful = doc_q.size();
    end
    return useful;
  endfunction

  // Send the built document; a cut one stops halfway with no last marker.
  task automatic send_doc(input bit cut);
    int n;
    n = cut ? doc_q.size() / 2 : doc_q.size();
    quiet_doc = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) send_word(doc_q[i], !cut && (i == n - 1));
  endtask

  initial begin
    logic [8:0]   directed [19];
    logic [127:0] chars;
    logic [63:0]  len_word;
    int           raw_len;
    int           fed;
    bit           held;
    bit           paused;

    // Directed documents under the reset tag (one zero byte): found with a
    // 0xff content byte and a tail ignored after it, a close before any
    // open, an open with no close, and a one-byte document.
    directed = '{
      {1'b0, CHAR_LT}, {1'b0, 8'h00}, {1'b0, CHAR_GT}, {1'b0, 8'hFF},
      {1'b0, CHAR_LT}, {1'b0, CHAR_SLASH}, {1'b0, 8'h00}, {1'b0, CHAR_GT},
      {1'b1, 8'h78},
      {1'b0, CHAR_LT}, {1'b0, CHAR_SLASH}, {1'b0, 8'h00}, {1'b0, CHAR_GT},
      {1'b1, 8'h7A},
      {1'b0, CHAR_LT}, {1'b0, 8'h00}, {1'b0, CHAR_GT}, {1'b1, 8'h71},
      {1'b1, 8'h00}
    };

    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_TAG_CHARS_LOW;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_byte   = '0;
    in_last   = 1'b0;
    quiet_doc = 1'b0;
    held      = 1'b0;
    paused    = 1'b0;
    sb = new();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    quiet_doc = 1'b1;
    foreach (directed[i]) send_word(directed[i][7:0], directed[i][8]);
    wait_idle();

    // Each phase loads a new tag. The first ones hit the extremes: length
    // one, sixteen bytes of all ones, an empty name of all zeros, and raw
    // lengths that saturate.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       raw_len = 1;
        1:       raw_len = 16;
        2:       raw_len = 0;
        3:       raw_len = 31;
        4:       raw_len = 17;
        5:       raw_len = 2;
        default: raw_len = $urandom_range(1, 16);
      endcase
      tag_eff = (raw_len > MAX_TAG_LEN) ? MAX_TAG_LEN : raw_len;
      for (int j = 0; j < 16; j++) begin
        if (ph == 1)
          tag_name[j] = 8'hFF;
        else if (ph == 2)
          tag_name[j] = 8'h00;
        else if ($urandom_range(0, 9) == 0)
          tag_name[j] = 8'($urandom_range(0, 255));
        else
          tag_name[j] = 8'h61 + 8'($urandom_range(0, 25));
        chars[8*j +: 8] = tag_name[j];
      end
      // upper bits of the length word are don't-care; scramble them at times
      len_word = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'd0;
      len_word[4:0] = 5'(raw_len);
      load_tag(chars, len_word);

      fed = 0;
      while (fed < PHASE_ITEMS) begin
        fed += build_doc();
        send_doc(1'b0);
        // hold the receiver off while bytes keep coming, so the block backs up
        if (ph == 3 && !held && fed >= 30) begin
          held = 1'b1;
          hold_req++;
        end
        // stop feeding once until every owed word has drained
        if (ph == 6 && !paused && fed >= 60) begin
          paused = 1'b1;
          wait_idle();
        end
      end

      // leave a document open across some tag changes
      if (ph < PHASES - 1 && (ph == 4 || $urandom_range(0, 3) == 0)) begin
        void'(build_doc());
        send_doc(1'b1);
      end
      wait_idle();
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
